// ===== sv/service_vip_backend_translator_defines.svh =====
// assertion helpers
`ifndef SERVICE_VIP_BACKEND_TRANSLATOR_DEFINES_SVH
`define SERVICE_VIP_BACKEND_TRANSLATOR_DEFINES_SVH
`define SVBT_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define SVBT_ASSERT_NEXT(label, clk, rstn, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) else $error(msg);
`endif

// ===== sv/svbt_pkg.sv =====
package svbt_pkg;
  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] address_family;
    logic [31:0] dest_ip;
    logic [15:0] dest_port;
    logic [31:0] owner_service_ip;
    logic [15:0] owner_service_port;
  } req_t;
  typedef struct packed {
    logic [31:0] out_ip;
    logic [15:0] out_port;
    logic [3:0]  status;
  } rsp_t;
  localparam logic [1:0] REQ_SVC = 2'd0;
  localparam logic [1:0] REQ_BE = 2'd1;
  localparam logic [1:0] REQ_XLATE = 2'd2;
  localparam logic [15:0] FAMILY_IPV4 = 16'd2;
  localparam logic [3:0] ST_REWRITTEN = 4'd0;
  localparam logic [3:0] ST_NOT_IPV4 = 4'd1;
  localparam logic [3:0] ST_NO_SVC = 4'd2;
  localparam logic [3:0] ST_NO_BE = 4'd3;
  localparam logic [3:0] ST_BE_MISSING = 4'd4;
  localparam logic [3:0] ST_SVC_ADDED = 4'd5;
  localparam logic [3:0] ST_SVC_EXISTS = 4'd6;
  localparam logic [3:0] ST_BE_ADDED = 4'd7;
  localparam logic [3:0] ST_BE_EXISTS = 4'd8;
  localparam logic [3:0] ST_SVC_UNKNOWN = 4'd9;
  localparam logic [3:0] ST_SLOTS_FULL = 4'd10;
  localparam logic [3:0] ST_TABLE_FULL = 4'd11;
  localparam logic [3:0] COUNT_MAX = 4'd15;
endpackage

// ===== sv/service_vip_backend_translator.sv =====
// Service address translation table. An item is taken when start_i is high and
// busy_o low; one result follows on rsp_o with done_o high for a single cycle and
// cannot be stalled. An item walks the service key memory, the backend key memory
// and the service slot memory one entry at a time. Every read is registered, so
// each entry has a read state and a check state. The longest item is a backend
// registration that reaches the last slot. Adding a service also clears all
// its slots.
module service_vip_backend_translator #(
  parameter int SERVICE_ENTRIES = 16,
  parameter int BACKENDS_PER_SERVICE = 8,
  parameter int BACKEND_ENTRIES = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  svbt_pkg::req_t    req_i,
  output logic              busy_o,
  output logic              done_o,
  output svbt_pkg::rsp_t    rsp_o
);
  import svbt_pkg::*;
  `include "service_vip_backend_translator_defines.svh"

  localparam int SW = (SERVICE_ENTRIES > 1) ? $clog2(SERVICE_ENTRIES) : 1;
  localparam int PW = (BACKENDS_PER_SERVICE > 1) ? $clog2(BACKENDS_PER_SERVICE) : 1;
  localparam int BW = (BACKEND_ENTRIES > 1) ? $clog2(BACKEND_ENTRIES) : 1;
  localparam int SLOTS = SERVICE_ENTRIES * BACKENDS_PER_SERVICE;
  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_BSCAN = 4'd2; // backend key memory scan
  localparam logic [3:0] S_BCHK = 4'd3;
  localparam logic [3:0] S_SLOT = 4'd4;  // slot memory scan
  localparam logic [3:0] S_SLOTCHK = 4'd5;
  localparam logic [3:0] S_CLEAR = 4'd6;
  localparam logic [3:0] S_DONE = 4'd7;
  localparam logic [3:0] S_SCAN_S = 4'd8;
  localparam logic [3:0] S_SCHK = 4'd9;

  logic [3:0] st_q, st_d;
  req_t req_q;
  logic [3:0] status_q, status_d;
  logic [31:0] oip_q, oip_d;
  logic [15:0] oport_q, oport_d;
  logic done_q, done_d;

  // service keys live in a memory too; valid bits and counts in flops
  logic [SERVICE_ENTRIES-1:0] svc_valid_q;
  logic [3:0] svc_cnt_q [SERVICE_ENTRIES];
  logic [47:0] skey_mem [SERVICE_ENTRIES];
  logic [47:0] skey_rd;
  logic [SW-1:0] skey_ra;
  logic [BACKEND_ENTRIES-1:0] be_valid_q;
  logic [47:0] bkey_mem [BACKEND_ENTRIES];
  logic [47:0] bkey_rd;
  logic [BW-1:0] bkey_ra;
  logic [47:0] slot_mem [SLOTS];
  logic [47:0] slot_rd;
  logic [AW-1:0] slot_ra;

  logic [BW:0] bi_q, bi_d;
  logic [SW:0] si_q, si_d;
  logic [PW:0] pi_q, pi_d;
  logic [SW-1:0] svc_q, svc_d;
  logic [47:0] bkey_q, bkey_d;
  logic phase_q, phase_d; // 0: dup/lookup key, 1: slot0 backend check

  logic slot_we, skey_we, bkey_we;
  logic [AW-1:0] slot_wa;
  logic [47:0] slot_wd;
  logic [SW-1:0] skey_wa;
  logic [BW-1:0] bkey_wa;
  logic set_svc, set_be, inc_cnt;
  logic [SW-1:0] free_s;
  logic free_s_ok;
  logic [BW-1:0] free_b;
  logic free_b_ok;
  logic [47:0] key, okey;

  assign key  = {req_q.dest_ip, req_q.dest_port};
  assign okey = {req_q.owner_service_ip, req_q.owner_service_port};

  always_comb begin
    free_s = '0;
    free_s_ok = 1'b0;
    for (int i = SERVICE_ENTRIES - 1; i >= 0; i--) begin
      if (!svc_valid_q[i]) begin
        free_s = SW'(i);
        free_s_ok = 1'b1;
      end
    end
  end

  always_comb begin
    free_b = '0;
    free_b_ok = 1'b0;
    for (int i = BACKEND_ENTRIES - 1; i >= 0; i--) begin
      if (!be_valid_q[i]) begin
        free_b = BW'(i);
        free_b_ok = 1'b1;
      end
    end
  end

  assign skey_ra = si_d[SW-1:0];
  assign bkey_ra = bi_d[BW-1:0];
  assign slot_ra = AW'(int'(svc_d) * BACKENDS_PER_SERVICE + int'(pi_d[PW-1:0]));

  always_ff @(posedge clk_i) begin
    skey_rd <= skey_mem[skey_ra];
    if (skey_we) skey_mem[skey_wa] <= key;
  end
  always_ff @(posedge clk_i) begin
    bkey_rd <= bkey_mem[bkey_ra];
    if (bkey_we) bkey_mem[bkey_wa] <= key;
  end
  always_ff @(posedge clk_i) begin
    slot_rd <= slot_mem[slot_ra];
    if (slot_we) slot_mem[slot_wa] <= slot_wd;
  end

  always_comb begin
    st_d = st_q;
    status_d = status_q;
    oip_d = oip_q;
    oport_d = oport_q;
    done_d = 1'b0;
    bi_d = bi_q;
    si_d = si_q;
    pi_d = pi_q;
    svc_d = svc_q;
    bkey_d = bkey_q;
    phase_d = phase_q;
    slot_we = 1'b0;
    slot_wa = AW'(int'(svc_q) * BACKENDS_PER_SERVICE + int'(pi_q[PW-1:0]));
    slot_wd = '0;
    skey_we = 1'b0;
    skey_wa = free_s;
    bkey_we = 1'b0;
    bkey_wa = free_b;
    set_svc = 1'b0;
    set_be = 1'b0;
    inc_cnt = 1'b0;
    unique case (st_q)
      S_IDLE: begin
        if (start_i) begin
          oip_d = req_i.dest_ip;
          oport_d = req_i.dest_port;
          phase_d = 1'b0;
          bi_d = '0;
          si_d = '0;
          pi_d = '0;
          unique case (req_i.req_type)
            REQ_SVC: st_d = S_SCAN_S;
            REQ_BE: st_d = S_BSCAN;
            REQ_XLATE: begin
              if (req_i.address_family != FAMILY_IPV4) begin
                status_d = ST_NOT_IPV4;
                st_d = S_DONE;
              end else begin
                st_d = S_SCAN_S;
              end
            end
            default: begin
              status_d = ST_NOT_IPV4;
              st_d = S_DONE;
            end
          endcase
        end
      end
      S_SCAN_S: st_d = S_SCHK; // read of skey_mem[si] in flight
      S_SCHK: begin
        if (svc_valid_q[si_q[SW-1:0]] && skey_rd == (req_q.req_type == REQ_BE ? okey : key)) begin
          svc_d = si_q[SW-1:0];
          unique case (req_q.req_type)
            REQ_SVC: begin
              status_d = ST_SVC_EXISTS;
              st_d = S_DONE;
            end
            REQ_BE: begin
              pi_d = '0;
              st_d = S_SLOT;
            end
            default: begin
              if (svc_cnt_q[si_q[SW-1:0]] == '0) begin
                status_d = ST_NO_BE;
                st_d = S_DONE;
              end else begin
                pi_d = '0;
                st_d = S_SLOT;
              end
            end
          endcase
        end else if (int'(si_q) == SERVICE_ENTRIES - 1) begin
          unique case (req_q.req_type)
            REQ_SVC: begin
              if (free_s_ok) begin
                skey_we = 1'b1;
                set_svc = 1'b1;
                svc_d = free_s;
                pi_d = '0;
                st_d = S_CLEAR;
              end else begin
                status_d = ST_TABLE_FULL;
                st_d = S_DONE;
              end
            end
            REQ_BE: begin
              status_d = ST_SVC_UNKNOWN;
              st_d = S_DONE;
            end
            default: begin
              status_d = ST_NO_SVC;
              st_d = S_DONE;
            end
          endcase
        end else begin
          si_d = si_q + 1'b1;
          st_d = S_SCAN_S;
        end
      end
      S_CLEAR: begin
        slot_we = 1'b1;
        if (int'(pi_q) == BACKENDS_PER_SERVICE - 1) begin
          status_d = ST_SVC_ADDED;
          st_d = S_DONE;
        end else begin
          pi_d = pi_q + 1'b1;
        end
      end
      S_BSCAN: st_d = S_BCHK;
      S_BCHK: begin
        if (be_valid_q[bi_q[BW-1:0]] && bkey_rd == (phase_q ? bkey_q : key)) begin
          if (phase_q) begin
            oip_d = bkey_q[47:16];
            oport_d = bkey_q[15:0];
            status_d = ST_REWRITTEN;
          end else begin
            status_d = ST_BE_EXISTS;
          end
          st_d = S_DONE;
        end else if (int'(bi_q) == BACKEND_ENTRIES - 1) begin
          if (phase_q) begin
            status_d = ST_BE_MISSING;
            st_d = S_DONE;
          end else begin
            si_d = '0;
            st_d = S_SCAN_S;
          end
        end else begin
          bi_d = bi_q + 1'b1;
          st_d = S_BSCAN;
        end
      end
      S_SLOT: st_d = S_SLOTCHK;
      S_SLOTCHK: begin
        if (req_q.req_type == REQ_XLATE) begin
          bkey_d = slot_rd;
          phase_d = 1'b1;
          bi_d = '0;
          st_d = S_BSCAN;
        end else if (slot_rd[47:16] == '0) begin
          if (free_b_ok) begin
            slot_we = 1'b1;
            slot_wd = key;
            bkey_we = 1'b1;
            set_be = 1'b1;
            inc_cnt = 1'b1;
            status_d = ST_BE_ADDED;
          end else begin
            status_d = ST_TABLE_FULL;
          end
          st_d = S_DONE;
        end else if (int'(pi_q) == BACKENDS_PER_SERVICE - 1) begin
          status_d = ST_SLOTS_FULL;
          st_d = S_DONE;
        end else begin
          pi_d = pi_q + 1'b1;
          st_d = S_SLOT;
        end
      end
      S_DONE: begin
        done_d = 1'b1;
        st_d = S_IDLE;
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      done_q <= 1'b0;
      svc_valid_q <= '0;
      be_valid_q <= '0;
    end else begin
      st_q <= st_d;
      done_q <= done_d;
      if (set_svc) svc_valid_q[free_s] <= 1'b1;
      if (set_be) be_valid_q[free_b] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == S_IDLE && start_i) req_q <= req_i;
    status_q <= status_d;
    oip_q <= oip_d;
    oport_q <= oport_d;
    bi_q <= bi_d;
    si_q <= si_d;
    pi_q <= pi_d;
    svc_q <= svc_d;
    bkey_q <= bkey_d;
    phase_q <= phase_d;
    if (set_svc) svc_cnt_q[free_s] <= '0;
    if (inc_cnt && svc_cnt_q[svc_q] != COUNT_MAX) svc_cnt_q[svc_q] <= svc_cnt_q[svc_q] + 1'b1;
  end

  assign busy_o = (st_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o = '{out_ip: oip_q, out_port: oport_q, status: status_q};

  `SVBT_ASSERT_NEXT(a_done_from_done_state, clk_i, rst_ni, st_q == S_DONE, done_o,
    "result missing after final state")
  `SVBT_ASSERT(a_done_idle, clk_i, rst_ni, !done_o || !busy_o || st_q != S_DONE,
    "result while still in final state")
  `SVBT_ASSERT_NEXT(a_svc_write_valid, clk_i, rst_ni, set_svc, svc_valid_q[svc_q],
    "service write without valid")
endmodule
